@@ rtl/pida_pkg.sv @@
`default_nettype none

package pida_pkg;

  // Default number of entries.
  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned WordW = 32;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned ErrW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_RESIZE = 3'd4
  } pida_req_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK     = 2'd0,
    ERR_POS    = 2'd1,
    ERR_FULL   = 2'd2,
    ERR_LENGTH = 2'd3
  } pida_err_e;

  // Per-cycle command broadcast to every cell; only one bit is high at a time.
  typedef struct packed {
    logic do_write;
    logic do_insert;
    logic do_delete;
    logic do_resize;
  } pida_cmd_t;

endpackage

`default_nettype wire

@@ rtl/pida_cell.sv @@
`default_nettype none

module pida_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 4,
  parameter int unsigned LW  = 5
) (
  input  wire logic                         clk_i,
  input  wire pida_pkg::pida_cmd_t          cmd_i,
  input  wire logic [PW-1:0]                pos_i,
  input  wire logic [LW-1:0]                len_i,
  input  wire logic [LW-1:0]                new_len_i,
  input  wire logic [pida_pkg::WordW-1:0]   word_i,
  input  wire logic [pida_pkg::WordW-1:0]   left_i,
  input  wire logic [pida_pkg::WordW-1:0]   right_i,
  output logic      [pida_pkg::WordW-1:0]   data_o
);

  localparam logic [LW-1:0] Idx = LW'(IDX);

  logic [pida_pkg::WordW-1:0] data_q, data_d;
  logic [LW-1:0]              pos_x;
  logic                       at_pos, past_pos, below_len, in_tail, in_grow;

  assign pos_x     = LW'(pos_i);
  assign at_pos    = (Idx == pos_x);
  assign past_pos  = (Idx > pos_x);
  assign below_len = (Idx < len_i);
  // i + 1 < len: this cell takes its right neighbor on a delete
  assign in_tail   = ({1'b0, Idx} + (LW+1)'(1)) < {1'b0, len_i};
  assign in_grow   = !below_len && (Idx < new_len_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.do_write && at_pos) begin
      data_d = word_i;
    end else if (cmd_i.do_insert) begin
      if (at_pos) begin
        data_d = word_i;
      end else if (past_pos && (Idx <= len_i)) begin
        data_d = left_i;
      end
    end else if (cmd_i.do_delete) begin
      if ((at_pos || past_pos) && in_tail) begin
        data_d = right_i;
      end
    end else if (cmd_i.do_resize && in_grow) begin
      data_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ rtl/positional_insert_delete_array_unit.sv @@
// Positional insert/delete array: a list of up to DEPTH signed 32-bit words
// held in a row of cells, one word per cell, each cell loading from its left
// or right neighbor so an insert or delete shifts the whole tail at once.
//
// Request channel (req_valid_i / req_ready_o): req_type_i selects read,
// write, insert, delete or resize; position_i, word_in_i and new_length_i
// are its operands. Response channel (rsp_valid_o / rsp_ready_i) carries
// word_out_o (read data, zero otherwise), length_now_o (length after the
// request) and error_code_o. Refused requests change nothing.
//
// The response is registered for the cycle after acceptance. Throughput: one
// request per cycle unless the receiver stalls; decode and cell update set it.
// The response sits in an output register: a new request is taken in the
// same cycle the held response is taken, so a stalled receiver holds the
// response and blocks further requests until it is consumed.
//
// Reset clears the length to zero and drops any pending response. Cell
// contents are not reset; growing by resize zeroes the new cells.
`default_nettype none

module positional_insert_delete_array_unit #(
  parameter int unsigned DEPTH = pida_pkg::DefaultDepth,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request
  input  wire logic                              req_valid_i,
  output logic                                   req_ready_o,
  input  wire logic [pida_pkg::ReqW-1:0]         req_type_i,
  input  wire logic [PW-1:0]                     position_i,
  input  wire logic signed [pida_pkg::WordW-1:0] word_in_i,
  input  wire logic [LW-1:0]                     new_length_i,
  // response
  output logic                                   rsp_valid_o,
  input  wire logic                              rsp_ready_i,
  output logic signed [pida_pkg::WordW-1:0]      word_out_o,
  output logic [LW-1:0]                          length_now_o,
  output logic [pida_pkg::ErrW-1:0]              error_code_o
);

  localparam logic [LW-1:0] DepthL = LW'(DEPTH);

  logic                       accept;
  logic [LW-1:0]              len_q, len_d;
  logic [LW-1:0]              pos_x;
  pida_pkg::pida_cmd_t        cmd;
  pida_pkg::pida_err_e        err;
  logic [pida_pkg::WordW-1:0] rd_data;
  logic [pida_pkg::WordW-1:0] cell_data [DEPTH];

  logic                       rsp_valid_q;
  logic [pida_pkg::WordW-1:0] word_out_q;
  logic [LW-1:0]              length_now_q;
  pida_pkg::pida_err_e        error_code_q;

  // Take a request whenever the output register is free or being drained.
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign pos_x       = LW'(position_i);

  // Request decode: bounds checks, next length and the cell command.
  always_comb begin
    err     = pida_pkg::ERR_OK;
    len_d   = len_q;
    rd_data = '0;
    cmd     = '0;
    case (pida_pkg::pida_req_e'(req_type_i))
      pida_pkg::REQ_READ: begin
        if (pos_x >= len_q) begin
          err = pida_pkg::ERR_POS;
        end else begin
          rd_data = cell_data[position_i];
        end
      end
      pida_pkg::REQ_WRITE: begin
        if (pos_x >= len_q) begin
          err = pida_pkg::ERR_POS;
        end else begin
          cmd.do_write = 1'b1;
        end
      end
      pida_pkg::REQ_INSERT: begin
        // position equal to length appends; range is checked before fullness
        if (pos_x > len_q) begin
          err = pida_pkg::ERR_POS;
        end else if (len_q >= DepthL) begin
          err = pida_pkg::ERR_FULL;
        end else begin
          cmd.do_insert = 1'b1;
          len_d         = len_q + LW'(1);
        end
      end
      pida_pkg::REQ_DELETE: begin
        if (pos_x >= len_q) begin
          err = pida_pkg::ERR_POS;
        end else begin
          cmd.do_delete = 1'b1;
          len_d         = len_q - LW'(1);
        end
      end
      pida_pkg::REQ_RESIZE: begin
        if (new_length_i > DepthL) begin
          err = pida_pkg::ERR_LENGTH;
        end else begin
          cmd.do_resize = 1'b1;
          len_d         = new_length_i;
        end
      end
      default: begin
        // unknown request type: no change, no error
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
  end

  // Row of cells; cell i sees cell i-1 on its left and cell i+1 on its right.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [pida_pkg::WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    pida_cell #(
      .IDX (g),
      .PW  (PW),
      .LW  (LW)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .pos_i     (position_i),
      .len_i     (len_q),
      .new_len_i (new_length_i),
      .word_i    (word_in_i),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_o    (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        len_q       <= len_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload, loaded only on an accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q   <= rd_data;
      length_now_q <= len_d;
      error_code_q <= err;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign word_out_o   = word_out_q;
  assign length_now_o = length_now_q;
  assign error_code_o = error_code_q;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DepthL)
    else $error("length exceeds depth");

  a_rsp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> length_now_o == len_q)
    else $error("response length differs from stored length");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && error_code_o != pida_pkg::ERR_OK) |-> word_out_o == '0)
    else $error("refused request returned data");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.do_insert) |=> len_q == $past(len_q) + LW'(1))
    else $error("insert did not grow length");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.do_delete) |=> len_q == $past(len_q) - LW'(1))
    else $error("delete did not shrink length");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err != pida_pkg::ERR_OK) |=> $stable(len_q))
    else $error("refused request changed length");
`endif

endmodule

`default_nettype wire
